@@ rtl/imu_tra_pkg.sv @@
//------------------------------------------------------------------------------
// IMU tilt and rate accumulator package
// Shared types, register indexes, sequencer states and arithmetic helpers.
//------------------------------------------------------------------------------
`default_nettype none

package imu_tra_pkg;

  localparam int ATAN_ENTRIES  = 24;
  localparam int STEP_IDX_W    = 5;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 15;
  localparam int RATE_W        = 19;
  localparam int TILT_W        = 17;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GYRO_BIAS_X = 2'd0,
    REG_GYRO_BIAS_Y = 2'd1,
    REG_GYRO_BIAS_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_ROT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic signed [15:0] acc_word0;
    logic signed [15:0] acc_word1;
    logic signed [15:0] acc_word2;
    logic signed [15:0] gyro_word0;
    logic signed [15:0] gyro_word1;
    logic signed [15:0] gyro_word2;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_tilt_total;
    logic signed [31:0] y_tilt_total;
    logic signed [39:0] x_rate_total;
    logic signed [39:0] y_rate_total;
    logic signed [39:0] z_rate_total;
    logic        [15:0] sample_total;
    logic               zero_vector;
  } out_item_t;

  // atan(2^-i) in degrees times 2^16.
  function automatic logic [21:0] atan_deg16(input logic [STEP_IDX_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // floor((56*b + 12) / 25) for a remainder b below 25.
  function automatic logic [5:0] rate_frac(input logic [4:0] b);
    logic [5:0] v;
    unique case (b)
      5'd0:  v = 6'd0;   5'd1:  v = 6'd2;   5'd2:  v = 6'd4;   5'd3:  v = 6'd7;
      5'd4:  v = 6'd9;   5'd5:  v = 6'd11;  5'd6:  v = 6'd13;  5'd7:  v = 6'd16;
      5'd8:  v = 6'd18;  5'd9:  v = 6'd20;  5'd10: v = 6'd22;  5'd11: v = 6'd25;
      5'd12: v = 6'd27;  5'd13: v = 6'd29;  5'd14: v = 6'd31;  5'd15: v = 6'd34;
      5'd16: v = 6'd36;  5'd17: v = 6'd38;  5'd18: v = 6'd40;  5'd19: v = 6'd43;
      5'd20: v = 6'd45;  5'd21: v = 6'd47;  5'd22: v = 6'd49;  5'd23: v = 6'd52;
      5'd24: v = 6'd54;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

  // round(raw * 56 / 25) minus bias, ties away from zero. The magnitude is
  // split as 25*a + b, with a from a reciprocal multiply that is exact below 2^16.
  function automatic logic signed [RATE_W-1:0] gyro_rate(
      input logic signed [15:0] raw, input logic signed [CFG_DATA_W-1:0] bias);
    logic [16:0] mag;
    logic [33:0] prod;
    logic [11:0] a;
    logic [16:0] a25;
    logic [4:0]  b;
    logic [16:0] q;
    logic signed [RATE_W-1:0] sq;
    mag  = raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};
    prod = {17'd0, mag} * 34'd83887;
    a    = prod[32:21];
    a25  = {5'd0, a} * 17'd25;
    b    = 5'(mag - a25);
    q    = ({5'd0, a} * 17'd56) + {11'd0, rate_frac(b)};
    sq   = raw[15] ? -$signed({2'b00, q}) : $signed({2'b00, q});
    return sq - RATE_W'(bias);
  endfunction

endpackage

`default_nettype wire

@@ rtl/imu_tra_in_if.sv @@
//------------------------------------------------------------------------------
// IMU sample channel
// Valid/ready channel carrying one sensor sample per transaction.
//------------------------------------------------------------------------------
`default_nettype none

interface imu_tra_in_if;
  logic                 valid;
  logic                 ready;
  imu_tra_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/imu_tra_out_if.sv @@
//------------------------------------------------------------------------------
// IMU result channel
// Valid/ready channel carrying the accumulated totals per transaction.
//------------------------------------------------------------------------------
`default_nettype none

interface imu_tra_out_if;
  logic                  valid;
  logic                  ready;
  imu_tra_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/imu_tra_isqrt.sv @@
//------------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit root of a 32-bit operand, one bit pair per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module imu_tra_isqrt (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [31:0]             operand,
  output imu_tra_pkg::unit_stat_t      stat,
  output logic      [15:0]             root
);

  logic [31:0] n_r, n_nxt;
  logic [31:0] res_r, res_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] bit_v;
  logic [32:0] trial;

  assign bit_v = 32'h4000_0000 >> {cnt_r, 1'b0};
  assign trial = {1'b0, res_r} + {1'b0, bit_v};

  always_comb begin
    n_nxt    = n_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = operand;
      res_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, n_r} >= trial) begin
        n_nxt   = n_r - trial[31:0];
        res_nxt = (res_r >> 1) + bit_v;
      end else begin
        res_nxt = res_r >> 1;
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = res_r[15:0];

endmodule

`default_nettype wire

@@ rtl/imu_tra_cordic.sv @@
//------------------------------------------------------------------------------
// Iterative vectoring CORDIC
// Rotates (radius, axis) onto the x axis and returns the angle in Q.8 degrees.
//------------------------------------------------------------------------------
`default_nettype none

module imu_tra_cordic #(
  parameter int CORDIC_STEPS = imu_tra_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic        [15:0]      radius,
  input  wire logic signed [15:0]      axis,
  output imu_tra_pkg::unit_stat_t      stat,
  output logic signed [imu_tra_pkg::TILT_W-1:0] angle_q8
);

  localparam int EFF_STEPS = (CORDIC_STEPS < imu_tra_pkg::ATAN_ENTRIES) ?
                             CORDIC_STEPS : imu_tra_pkg::ATAN_ENTRIES;
  localparam logic [imu_tra_pkg::STEP_IDX_W-1:0] LAST_IDX =
      imu_tra_pkg::STEP_IDX_W'(EFF_STEPS - 1);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [24:0] z_r, z_nxt;
  logic [imu_tra_pkg::STEP_IDX_W-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic signed [33:0] dx, dy;
  logic signed [24:0] ang;
  logic        [24:0] zmag, zrnd;

  assign dx  = y_r >>> i_r;
  assign dy  = x_r >>> i_r;
  assign ang = $signed({3'b000, imu_tra_pkg::atan_deg16(i_r)});

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = $signed({4'b0000, radius, 14'd0});
      y_nxt    = $signed({{4{axis[15]}}, axis, 14'd0});
      z_nxt    = '0;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!y_r[33]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + ang;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - ang;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == LAST_IDX) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r    <= i_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  // Round to 1/256 degree, ties away from zero.
  assign zmag = z_r[24] ? 25'(-z_r) : 25'(z_r);
  assign zrnd = (zmag + 25'd128) >> 8;
  assign angle_q8 = z_r[24] ? -$signed(zrnd[imu_tra_pkg::TILT_W-1:0])
                            : $signed(zrnd[imu_tra_pkg::TILT_W-1:0]);

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

@@ rtl/imu_tilt_and_rate_accumulator_core.sv @@
//------------------------------------------------------------------------------
// IMU tilt and rate accumulator core
// Accumulates accelerometer tilt angles and bias-corrected gyro rates.
//------------------------------------------------------------------------------
// Each input transaction on in_ch is one sensor sample (three accelerometer
// and three gyro words plus a restart flag). Each accepted sample produces
// exactly one output transaction on out_ch with the running totals.
// The bias registers are written through cfg_we/cfg_addr/cfg_wdata; the user
// must write them only while the block is idle, which the block itself does
// not enforce. A write to an unused index is dropped. A sample with a
// nonzero acceleration vector makes two passes through the shared square
// root and the CORDIC rotator; an all-zero vector skips both passes. One
// sample is in flight at a time; in_ch.ready is high only while the
// sequencer is idle.
// The result sits in an output register, so a new sample is taken while the
// previous result waits. If the receiver still stalls when the next result is
// ready, the sequencer holds in its final step and the totals do not change.
// Reset (synchronous, active low) clears all sums, the count, the biases and
// the output valid.
//------------------------------------------------------------------------------
`default_nettype none

module imu_tilt_and_rate_accumulator_core #(
  parameter int CORDIC_STEPS = imu_tra_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  imu_tra_in_if.sink                                 in_ch,
  imu_tra_out_if.source                              out_ch,
  input  wire logic                                  cfg_we,
  input  wire logic [imu_tra_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [imu_tra_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  imu_tra_pkg::seq_state_t state_r, state_nxt;

  logic signed [imu_tra_pkg::CFG_DATA_W-1:0] bias_x_r, bias_y_r, bias_z_r;
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic               restart_r, zero_r, pass_r;
  logic signed [imu_tra_pkg::RATE_W-1:0] rate_x_r, rate_y_r, rate_z_r;
  logic signed [imu_tra_pkg::TILT_W-1:0] tilt_x_r, tilt_y_r;

  logic signed [31:0] x_tilt_sum_r, y_tilt_sum_r;
  logic signed [39:0] x_rate_sum_r, y_rate_sum_r, z_rate_sum_r;
  logic        [15:0] count_r;

  logic                   out_valid_r;
  imu_tra_pkg::out_item_t out_r;

  imu_tra_pkg::unit_stat_t sqrt_stat, cordic_stat;
  logic        sqrt_start, cordic_start, tilt_load, finish, accept;
  logic [15:0] root;
  logic signed [imu_tra_pkg::TILT_W-1:0] angle_q8;
  logic signed [15:0] p_sel, q_sel, axis_sel;
  logic [31:0] sq_sum;
  logic signed [15:0] ay_in, ax_in;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == imu_tra_pkg::ST_IDLE);

  // Negating the most negative word saturates to the most positive one.
  assign ay_in = (in_ch.payload.acc_word0 == 16'sh8000) ? 16'sh7fff
                                                       : -in_ch.payload.acc_word0;
  assign ax_in = (in_ch.payload.acc_word1 == 16'sh8000) ? 16'sh7fff
                                                       : -in_ch.payload.acc_word1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_x_r <= '0;
      bias_y_r <= '0;
      bias_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        imu_tra_pkg::REG_GYRO_BIAS_X: bias_x_r <= cfg_wdata;
        imu_tra_pkg::REG_GYRO_BIAS_Y: bias_y_r <= cfg_wdata;
        imu_tra_pkg::REG_GYRO_BIAS_Z: bias_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pass 0 works out the X tilt, pass 1 the Y tilt; both share the root and
  // the rotator. The radius is formed from the two other axes.
  assign p_sel    = pass_r ? ax_r : ay_r;
  assign q_sel    = az_r;
  assign axis_sel = pass_r ? ay_r : ax_r;
  assign sq_sum   = 32'(p_sel * p_sel) + 32'(q_sel * q_sel);

  imu_tra_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .operand (sq_sum),
    .stat    (sqrt_stat),
    .root    (root)
  );

  imu_tra_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cordic_start),
    .radius   (root),
    .axis     (axis_sel),
    .stat     (cordic_stat),
    .angle_q8 (angle_q8)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imu_tra_pkg::ST_IDLE: if (accept) state_nxt = imu_tra_pkg::ST_SQ;
      imu_tra_pkg::ST_SQ:   state_nxt = zero_r ? imu_tra_pkg::ST_DONE
                                               : imu_tra_pkg::ST_ROOT;
      imu_tra_pkg::ST_ROOT: if (sqrt_stat.done) state_nxt = imu_tra_pkg::ST_ROT;
      imu_tra_pkg::ST_ROT: begin
        if (cordic_stat.done) begin
          state_nxt = pass_r ? imu_tra_pkg::ST_DONE : imu_tra_pkg::ST_SQ;
        end
      end
      imu_tra_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = imu_tra_pkg::ST_IDLE;
      end
      default: state_nxt = imu_tra_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    sqrt_start   = 1'b0;
    cordic_start = 1'b0;
    tilt_load    = 1'b0;
    finish       = 1'b0;
    unique case (state_r)
      imu_tra_pkg::ST_SQ:   sqrt_start   = !zero_r;
      imu_tra_pkg::ST_ROOT: cordic_start = sqrt_stat.done;
      imu_tra_pkg::ST_ROT:  tilt_load    = cordic_stat.done;
      imu_tra_pkg::ST_DONE: finish       = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imu_tra_pkg::ST_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        pass_r <= 1'b0;
      end else if (tilt_load) begin
        pass_r <= 1'b1;
      end
    end
  end

  // Sample and per-sample result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r      <= ax_in;
      ay_r      <= ay_in;
      az_r      <= in_ch.payload.acc_word2;
      gy_r      <= in_ch.payload.gyro_word0;
      gx_r      <= in_ch.payload.gyro_word1;
      gz_r      <= in_ch.payload.gyro_word2;
      restart_r <= in_ch.payload.restart;
      zero_r    <= (ax_in == 16'sd0) && (ay_in == 16'sd0) &&
                   (in_ch.payload.acc_word2 == 16'sd0);
    end
    if (state_r == imu_tra_pkg::ST_SQ) begin
      rate_x_r <= imu_tra_pkg::gyro_rate(gx_r, bias_x_r);
      rate_y_r <= imu_tra_pkg::gyro_rate(gy_r, bias_y_r);
      rate_z_r <= imu_tra_pkg::gyro_rate(gz_r, bias_z_r);
    end
    if (tilt_load) begin
      if (pass_r) begin
        tilt_y_r <= angle_q8;
      end else begin
        tilt_x_r <= angle_q8;
      end
    end
  end

  // Saturating accumulation; restart clears the sums before this sample.
  logic signed [31:0] xt_base, yt_base;
  logic signed [39:0] xr_base, yr_base, zr_base;
  logic        [15:0] cnt_base;
  logic signed [32:0] xt_sum, yt_sum;
  logic signed [40:0] xr_sum, yr_sum, zr_sum;
  logic signed [31:0] xt_nxt, yt_nxt;
  logic signed [39:0] xr_nxt, yr_nxt, zr_nxt;
  logic        [15:0] cnt_nxt;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    logic signed [39:0] r;
    if (v[40] != v[39]) begin
      r = v[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

  always_comb begin
    xt_base  = restart_r ? '0 : x_tilt_sum_r;
    yt_base  = restart_r ? '0 : y_tilt_sum_r;
    xr_base  = restart_r ? '0 : x_rate_sum_r;
    yr_base  = restart_r ? '0 : y_rate_sum_r;
    zr_base  = restart_r ? '0 : z_rate_sum_r;
    cnt_base = restart_r ? '0 : count_r;
    xt_sum   = 33'(xt_base) + (zero_r ? 33'sd0 : 33'(tilt_x_r));
    yt_sum   = 33'(yt_base) + (zero_r ? 33'sd0 : 33'(tilt_y_r));
    xr_sum   = 41'(xr_base) + 41'(rate_x_r);
    yr_sum   = 41'(yr_base) + 41'(rate_y_r);
    zr_sum   = 41'(zr_base) + 41'(rate_z_r);
    xt_nxt   = sat32(xt_sum);
    yt_nxt   = sat32(yt_sum);
    xr_nxt   = sat40(xr_sum);
    yr_nxt   = sat40(yr_sum);
    zr_nxt   = sat40(zr_sum);
    cnt_nxt  = (cnt_base == 16'hffff) ? cnt_base : cnt_base + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_tilt_sum_r <= '0;
      y_tilt_sum_r <= '0;
      x_rate_sum_r <= '0;
      y_rate_sum_r <= '0;
      z_rate_sum_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (finish) begin
        x_tilt_sum_r <= xt_nxt;
        y_tilt_sum_r <= yt_nxt;
        x_rate_sum_r <= xr_nxt;
        y_rate_sum_r <= yr_nxt;
        z_rate_sum_r <= zr_nxt;
        count_r      <= cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
    if (finish) begin
      out_r.x_tilt_total <= xt_nxt;
      out_r.y_tilt_total <= yt_nxt;
      out_r.x_rate_total <= xr_nxt;
      out_r.y_rate_total <= yr_nxt;
      out_r.z_rate_total <= zr_nxt;
      out_r.sample_total <= cnt_nxt;
      out_r.zero_vector  <= zero_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // A new sample is only taken when neither arithmetic unit is working.
  a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !sqrt_stat.busy && !cordic_stat.busy)
    else $error("sample accepted while an arithmetic unit is busy");

  // Every fresh result counts at least one sample.
  a_result_counted: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_r.sample_total != 16'd0)
    else $error("result delivered with a zero sample count");

  // A zero vector never starts the square root.
  a_zero_skips_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == imu_tra_pkg::ST_SQ) && zero_r |=> !sqrt_stat.busy)
    else $error("square root started for a zero acceleration vector");

endmodule

`default_nettype wire
